// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the keyframe sampler.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define KV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kvls: assertion failed");

// clocked property that is also checked during reset
`define KV_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("kvls: reset check failed");

`endif

// ===== sv/kvls_pkg.sv =====
// Package for the keyframe vector sampler: sizes, codes and the structs
// passed between controller, datapath and register block. No dependencies.
`default_nettype none

package kvls_pkg;

    localparam int MAX_KEYS = 64;
    localparam int ADDR_W   = $clog2(MAX_KEYS);
    localparam int KIDX_W   = 6;
    localparam int KCNT_W   = 7;
    localparam int APB_AW   = 4;
    localparam int FRAC_W   = 17;
    localparam int CNT_W    = 6;

    // divider step counts
    localparam logic [CNT_W-1:0] FRAC_STEPS = CNT_W'(FRAC_W);
    localparam logic [CNT_W-1:0] MOD_STEPS  = CNT_W'(33);

    // item commands
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // register indexes
    localparam logic [1:0] REG_KEY_COUNT = 2'd0;
    localparam logic [1:0] REG_DURATION  = 2'd1;
    localparam logic [1:0] REG_STEP      = 2'd2;

    // vector components
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef struct packed {
        logic [31:0] stamp;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } kvls_entry_t;

    localparam int ENTRY_W = $bits(kvls_entry_t);

    typedef struct packed {
        logic [KCNT_W-1:0] key_count;
        logic [31:0]       clip_duration;
        logic [31:0]       tick_step;
    } kvls_cfg_t;

    typedef struct packed {
        logic       capture;
        logic       tick_start;
        logic       tick_load;
        logic       prev_load;
        logic       cur_load;
        logic       res_load;
        logic       frac_start;
        logic       f_clear;
        logic       f_take;
        logic       mul;
        logic       add;
        logic [1:0] comp;
        logic       out_load;
    } kvls_cmd_t;

    typedef struct packed {
        logic div_done;
        logic t_le_dout;
        logic hit;
        logic width_zero;
    } kvls_stat_t;

endpackage

`default_nettype wire

// ===== sv/keyframe_vector_lerp_sampler_core.sv =====
// A write item is taken in idle and leaves the block idle; a sample item walks the keys
// from index 1 up to the last key in use, then runs a 17-step serial fraction divide
// and a multiply and an add per component; the first-key, last-key and zero-width paths are shorter.
// A tick item first runs the 33-step modulo on the same divider, skipped when the clip duration is zero.
// Throughput: one item at a time; a write every cycle, a new sample once the output register is loaded.
// Reset (async, active low) clears control and running time and loads config defaults, not the table.
`default_nettype none

module keyframe_vector_lerp_sampler_core
    import kvls_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        command,
    input  wire logic [KIDX_W-1:0] key_index,
    input  wire logic [31:0]       key_time,
    input  wire logic signed [31:0] key_x,
    input  wire logic signed [31:0] key_y,
    input  wire logic signed [31:0] key_z,
    input  wire logic [31:0]       query_time,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [31:0]     out_x,
    output logic signed [31:0]     out_y,
    output logic signed [31:0]     out_z,
    output logic      [31:0]       used_time
);

    kvls_cfg_t         cfg;
    kvls_cmd_t         cmd;
    kvls_stat_t        stat;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_raddr;
    kvls_entry_t       ram_wdata;
    kvls_entry_t       ram_rdata;

    assign ram_wdata.stamp = key_time;
    assign ram_wdata.x     = key_x;
    assign ram_wdata.y     = key_y;
    assign ram_wdata.z     = key_z;

    kvls_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kvls_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_KEYS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(key_index)),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kvls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .key_index (key_index),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .key_count (cfg.key_count),
        .stat      (stat),
        .cmd       (cmd),
        .ram_we    (ram_we),
        .ram_raddr (ram_raddr)
    );

    kvls_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg),
        .query_time (query_time),
        .ram_rdata  (ram_rdata),
        .stat       (stat),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .used_time  (used_time)
    );

endmodule

`default_nettype wire

// ===== sv/kvls_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kvls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/kvls_regs.sv =====
// APB configuration registers: key count, clip duration, tick step.
// Depends on kvls_pkg.
`default_nettype none

module kvls_regs
    import kvls_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output kvls_cfg_t              cfg
);

    logic [KCNT_W-1:0] key_count_reg;
    logic [31:0]       duration_reg;
    logic [31:0]       step_reg;
    logic              wr;
    logic [1:0]        idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= KCNT_W'(1);
            duration_reg  <= 32'd65536;
            step_reg      <= 32'd1092;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_KEY_COUNT: key_count_reg <= pwdata[KCNT_W-1:0];
                REG_DURATION:  duration_reg  <= pwdata;
                REG_STEP:      step_reg      <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_KEY_COUNT: prdata = {{(32-KCNT_W){1'b0}}, key_count_reg};
            REG_DURATION:  prdata = duration_reg;
            REG_STEP:      prdata = step_reg;
            default:       prdata = '0;
        endcase
    end

    assign cfg.key_count     = key_count_reg;
    assign cfg.clip_duration = duration_reg;
    assign cfg.tick_step     = step_reg;

endmodule

`default_nettype wire

// ===== sv/kvls_ctrl.sv =====
// Controller: sequences write, tick divide, key walk, fraction divide,
// per-component mix and output hand-off. Depends on kvls_pkg.
`default_nettype none

module kvls_ctrl
    import kvls_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        command,
    input  wire logic [KIDX_W-1:0] key_index,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire logic [KCNT_W-1:0] key_count,
    input  wire kvls_stat_t        stat,
    output kvls_cmd_t              cmd,
    output logic                   ram_we,
    output logic      [ADDR_W-1:0] ram_raddr
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TDIV  = 3'd1;
    localparam logic [2:0] ST_FIRST = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_FDIV  = 3'd4;
    localparam logic [2:0] ST_MUL   = 3'd5;
    localparam logic [2:0] ST_ADD   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [1:0]        comp_reg, comp_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] last_idx;
    logic              one_key;
    logic              idx_ok;

    // index of the last key in use; zero counts as one, large counts saturate
    always_comb
    begin
        priority if (key_count == '0)
        begin
            last_idx = '0;
        end
        else if (32'(key_count) > 32'(MAX_KEYS))
        begin
            last_idx = ADDR_W'(MAX_KEYS - 1);
        end
        else
        begin
            last_idx = ADDR_W'(32'(key_count) - 32'd1);
        end
    end

    assign one_key   = (last_idx == '0);
    assign idx_ok    = (32'(key_index) < 32'(MAX_KEYS));
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    // read port follows the next address, so the RAM output always shows
    // the entry at addr_reg
    assign ram_raddr = addr_next;

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        comp_next      = comp_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.comp       = comp_reg;
        ram_we         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (command)
                        CMD_WRITE:  ram_we = idx_ok;
                        CMD_SAMPLE: state_next = ST_FIRST;
                        CMD_TICK:
                        begin
                            cmd.tick_start = 1'b1;
                            state_next     = ST_TDIV;
                        end
                        default:    ;
                    endcase
                end
            end
            ST_TDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.tick_load = 1'b1;
                    state_next    = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if (one_key || stat.t_le_dout)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    cmd.prev_load = 1'b1;
                    addr_next     = ADDR_W'(1);
                    state_next    = ST_WALK;
                end
            end
            ST_WALK:
            begin
                priority if (stat.hit)
                begin
                    cmd.cur_load = 1'b1;
                    addr_next    = '0;
                    comp_next    = COMP_X;
                    if (stat.width_zero)
                    begin
                        cmd.f_clear = 1'b1;
                        state_next  = ST_MUL;
                    end
                    else
                    begin
                        cmd.frac_start = 1'b1;
                        state_next     = ST_FDIV;
                    end
                end
                else if (addr_reg == last_idx)
                begin
                    cmd.res_load = 1'b1;
                    addr_next    = '0;
                    state_next   = ST_OUT;
                end
                else
                begin
                    cmd.prev_load = 1'b1;
                    addr_next     = ADDR_W'(addr_reg + 1'b1);
                end
            end
            ST_FDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.f_take = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add = 1'b1;
                if (comp_reg == COMP_Z)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            addr_reg      <= '0;
            comp_reg      <= COMP_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            comp_reg      <= comp_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/kvls_dp.sv =====
// Datapath: running clock, shared radix-2 divider, walk registers,
// multiply/add mix and output registers. Depends on kvls_pkg.
`default_nettype none

module kvls_dp
    import kvls_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire kvls_cmd_t    cmd,
    input  wire kvls_cfg_t    cfg,
    input  wire logic [31:0]  query_time,
    input  wire kvls_entry_t  ram_rdata,
    output kvls_stat_t        stat,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic      [31:0]  used_time
);

    logic [31:0]       running_reg;
    logic [CNT_W-1:0]  div_cnt_reg;
    logic [31:0]       div_rem_reg;
    logic [32:0]       div_q_reg;
    logic [31:0]       div_d_reg;
    logic [31:0]       t_reg;
    logic [31:0]       sum_reg;
    kvls_entry_t       prev_reg;
    kvls_entry_t       cur_reg;
    logic [FRAC_W-1:0] f_reg;
    logic signed [50:0] prod_reg;
    logic [31:0]       res_x_reg, res_y_reg, res_z_reg;
    logic [31:0]       out_x_reg, out_y_reg, out_z_reg, used_reg;

    logic [32:0]       sum33;
    logic              dur_zero;
    logic [31:0]       diff;
    logic [31:0]       width;
    logic [32:0]       shifted;
    logic              ge;
    logic [32:0]       sub;
    logic [31:0]       a_sel, b_sel;
    logic signed [32:0] delta;
    logic signed [50:0] prod;
    logic [31:0]       mixed;

    assign sum33    = {1'b0, running_reg} + {1'b0, cfg.tick_step};
    assign dur_zero = (cfg.clip_duration == '0);
    assign diff     = t_reg - prev_reg.stamp;
    assign width    = ram_rdata.stamp - prev_reg.stamp;

    // one restoring step per cycle; partial remainder stays below divisor
    assign shifted = {div_rem_reg, div_q_reg[32]};
    assign ge      = (shifted >= {1'b0, div_d_reg});
    assign sub     = shifted - {1'b0, div_d_reg};

    assign stat.div_done   = (div_cnt_reg == '0);
    assign stat.t_le_dout  = (t_reg <= ram_rdata.stamp);
    assign stat.hit        = (prev_reg.stamp <= t_reg) && (t_reg <= ram_rdata.stamp);
    assign stat.width_zero = (ram_rdata.stamp == prev_reg.stamp);

    always_comb
    begin
        unique case (cmd.comp)
            COMP_X:
            begin
                a_sel = prev_reg.x;
                b_sel = cur_reg.x;
            end
            COMP_Y:
            begin
                a_sel = prev_reg.y;
                b_sel = cur_reg.y;
            end
            default:
            begin
                a_sel = prev_reg.z;
                b_sel = cur_reg.z;
            end
        endcase
    end

    assign delta = $signed({b_sel[31], b_sel}) - $signed({a_sel[31], a_sel});
    assign prod  = delta * $signed({1'b0, f_reg});
    // a + floor(prod / 65536), wrapped to 32 bits
    assign mixed = a_sel + prod_reg[47:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.tick_load)
            begin
                running_reg <= dur_zero ? sum_reg : div_rem_reg;
            end
            priority if (cmd.tick_start)
            begin
                div_cnt_reg <= dur_zero ? '0 : MOD_STEPS;
            end
            else if (cmd.frac_start)
            begin
                div_cnt_reg <= FRAC_STEPS;
            end
            else if (div_cnt_reg != '0)
            begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (cmd.tick_start)
        begin
            div_rem_reg <= '0;
            div_q_reg   <= sum33;
            div_d_reg   <= cfg.clip_duration;
        end
        else if (cmd.frac_start)
        begin
            // dividend is diff << 16: top 31 bits preload the remainder
            div_rem_reg <= {1'b0, diff[31:1]};
            div_q_reg   <= {diff[0], 32'd0};
            div_d_reg   <= width;
        end
        else if (div_cnt_reg != '0)
        begin
            div_rem_reg <= ge ? sub[31:0] : shifted[31:0];
            div_q_reg   <= {div_q_reg[31:0], ge};
        end

        if (cmd.capture)
        begin
            t_reg   <= query_time;
            sum_reg <= sum33[31:0];
        end
        else if (cmd.tick_load)
        begin
            t_reg <= dur_zero ? sum_reg : div_rem_reg;
        end

        if (cmd.prev_load)
        begin
            prev_reg <= ram_rdata;
        end
        if (cmd.cur_load)
        begin
            cur_reg <= ram_rdata;
        end

        priority if (cmd.f_clear)
        begin
            f_reg <= '0;
        end
        else if (cmd.f_take)
        begin
            f_reg <= div_q_reg[FRAC_W-1:0];
        end

        if (cmd.mul)
        begin
            prod_reg <= prod;
        end

        if (cmd.res_load)
        begin
            res_x_reg <= ram_rdata.x;
            res_y_reg <= ram_rdata.y;
            res_z_reg <= ram_rdata.z;
        end
        else if (cmd.add)
        begin
            unique case (cmd.comp)
                COMP_X:  res_x_reg <= mixed;
                COMP_Y:  res_y_reg <= mixed;
                default: res_z_reg <= mixed;
            endcase
        end

        if (cmd.out_load)
        begin
            out_x_reg <= res_x_reg;
            out_y_reg <= res_y_reg;
            out_z_reg <= res_z_reg;
            used_reg  <= t_reg;
        end
    end

    assign out_x     = $signed(out_x_reg);
    assign out_y     = $signed(out_y_reg);
    assign out_z     = $signed(out_z_reg);
    assign used_time = used_reg;

endmodule

`default_nettype wire

// ===== sv/kvls_checker.sv =====
// Port-level checks for the keyframe sampler, bound to the top level.
// Depends on kvls_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module kvls_checker
    import kvls_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic [1:0]        command,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic signed [31:0] out_x,
    input wire logic signed [31:0] out_y,
    input wire logic signed [31:0] out_z,
    input wire logic [31:0]       used_time
);

    logic [127:0] out_word;
    logic         write_take;
    logic         sample_take;

    assign out_word    = {out_x, out_y, out_z, used_time};
    assign write_take  = in_valid && in_ready && (command == CMD_WRITE);
    assign sample_take = in_valid && in_ready && (command == CMD_SAMPLE || command == CMD_TICK);

    // a held result keeps its payload
    `KV_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_word))

    // a keyframe write never produces a result item
    `KV_ASSERT(a_write_silent, clk, rst_n, write_take && !out_valid |=> !out_valid)

    // a sample or tick item leaves the block busy in the cycle after it is taken
    `KV_ASSERT(a_sample_busy, clk, rst_n, sample_take |=> !in_ready)

    // once reset has been seen at an edge, nothing is offered and the input side is open
    `KV_ASSERT_RST(a_reset_state, clk, !rst_n |=> !out_valid && in_ready)

endmodule

bind keyframe_vector_lerp_sampler_core kvls_checker u_kvls_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_keyframe_vector_lerp_sampler_core.sv =====
// Testbench for keyframe_vector_lerp_sampler_core: directed table, then random phases,
// results checked against an in-bench keyframe interpolation predictor or typed rows.
// Depends on kvls_pkg and the core RTL only.
`default_nettype none

module tb_keyframe_vector_lerp_sampler_core;
    timeunit 1ns;
    timeprecision 1ps;

    import kvls_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int PHASES        = 6;
    localparam int MIX_ITEMS     = 150;
    localparam int STALL_AFTER   = 180;
    localparam int STALL_CYCLES  = 600;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  idx;
        logic [31:0] ktime;
        logic [31:0] kx;
        logic [31:0] ky;
        logic [31:0] kz;
        logic [31:0] qtime;
    } kv_item_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] used;
    } kv_sample_t;

    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  reg_idx;
        logic [31:0] reg_data;
        logic        typed;
        kv_item_t    item;
        kv_sample_t  want;
    } plan_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid, in_ready;
    logic [1:0]        command;
    logic [KIDX_W-1:0] key_index;
    logic [31:0]       key_time;
    logic signed [31:0] key_x, key_y, key_z;
    logic [31:0]       query_time;
    logic              out_valid, out_ready;
    logic signed [31:0] out_x, out_y, out_z;
    logic [31:0]       used_time;

    // predictor state
    logic [31:0] key_t_tbl [MAX_KEYS];
    logic [31:0] key_x_tbl [MAX_KEYS];
    logic [31:0] key_y_tbl [MAX_KEYS];
    logic [31:0] key_z_tbl [MAX_KEYS];
    logic [31:0] clock_q;
    logic [6:0]  cnt_cfg;
    logic [31:0] clip_cfg;
    logic [31:0] step_cfg;

    kv_sample_t pending_samples [$];
    kv_sample_t head_sample;
    plan_row_t  plan [$];

    int send_idle_pct = 37;
    int recv_idle_pct = 46;
    int samples_seen  = 0;
    int mismatch_count = 0;
    int cycle_count   = 0;
    int stall_left    = 0;
    bit stall_done    = 1'b0;

    keyframe_vector_lerp_sampler_core uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic kv_item_t mk_write(logic [5:0] idx, logic [31:0] t,
                                          logic [31:0] x, logic [31:0] y, logic [31:0] z);
        kv_item_t it;
        it = '0;
        it.cmd = CMD_WRITE;
        it.idx = idx;
        it.ktime = t;
        it.kx = x;
        it.ky = y;
        it.kz = z;
        return it;
    endfunction

    function automatic kv_item_t mk_query(logic [31:0] q);
        kv_item_t it;
        it = '0;
        it.cmd = CMD_SAMPLE;
        it.qtime = q;
        return it;
    endfunction

    function automatic kv_item_t mk_tick();
        kv_item_t it;
        it = '0;
        it.cmd = CMD_TICK;
        return it;
    endfunction

    function automatic kv_sample_t mk_sample(logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z, logic [31:0] used);
        kv_sample_t s;
        s.x = x;
        s.y = y;
        s.z = z;
        s.used = used;
        return s;
    endfunction

    function automatic plan_row_t row_item(kv_item_t it);
        plan_row_t r;
        r = '0;
        r.item = it;
        return r;
    endfunction

    function automatic plan_row_t row_typed(kv_item_t it, kv_sample_t want);
        plan_row_t r;
        r = '0;
        r.item = it;
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic plan_row_t row_cfg(logic [1:0] idx, logic [31:0] data);
        plan_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_data = data;
        return r;
    endfunction

    // a + floor((b - a) * f / 2^16), f is unsigned Q1.16 with 1.0 exact
    function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [16:0] f);
        longint sa, d, p, r;
        sa = $signed(a);
        d = $signed(b) - sa;
        p = d * $signed({47'd0, f});
        r = sa + (p >>> 16);
        return r[31:0];
    endfunction

    function automatic kv_sample_t sample_at(logic [31:0] t);
        kv_sample_t r;
        int n;
        logic [31:0] t0, t1;
        logic [63:0] num, den;
        logic [16:0] f;
        n = cnt_cfg;
        if (n == 0)
            n = 1;
        if (n > MAX_KEYS)
            n = MAX_KEYS;
        r.used = t;
        if (n == 1 || t <= key_t_tbl[0])
        begin
            r.x = key_x_tbl[0];
            r.y = key_y_tbl[0];
            r.z = key_z_tbl[0];
            return r;
        end
        r.x = key_x_tbl[n-1];
        r.y = key_y_tbl[n-1];
        r.z = key_z_tbl[n-1];
        // walk downward so the lowest holding interval is the one that sticks
        for (int i = n - 2; i >= 0; i--)
        begin
            t0 = key_t_tbl[i];
            t1 = key_t_tbl[i+1];
            if (t0 <= t && t <= t1)
            begin
                num = {32'd0, 32'(t - t0)} << 16;
                den = {32'd0, 32'(t1 - t0)};
                f = (den == 0) ? 17'd0 : 17'(num / den);
                r.x = blend(key_x_tbl[i], key_x_tbl[i+1], f);
                r.y = blend(key_y_tbl[i], key_y_tbl[i+1], f);
                r.z = blend(key_z_tbl[i], key_z_tbl[i+1], f);
            end
        end
        return r;
    endfunction

    function automatic void predict_item(kv_item_t it, output bit has, output kv_sample_t r);
        logic [32:0] s;
        has = 1'b0;
        r = '0;
        case (it.cmd)
            CMD_WRITE:
            begin
                key_t_tbl[it.idx] = it.ktime;
                key_x_tbl[it.idx] = it.kx;
                key_y_tbl[it.idx] = it.ky;
                key_z_tbl[it.idx] = it.kz;
            end
            CMD_SAMPLE:
            begin
                r = sample_at(it.qtime);
                has = 1'b1;
            end
            CMD_TICK:
            begin
                s = {1'b0, clock_q} + {1'b0, step_cfg};
                if (clip_cfg != 0)
                    s = s % {1'b0, clip_cfg};
                clock_q = s[31:0];
                r = sample_at(clock_q);
                has = 1'b1;
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    task automatic send_item(kv_item_t it, bit typed, kv_sample_t want);
        bit has;
        kv_sample_t pred;
        @(negedge clk);
        in_valid   <= 1'b1;
        command    <= it.cmd;
        key_index  <= it.idx;
        key_time   <= it.ktime;
        key_x      <= it.kx;
        key_y      <= it.ky;
        key_z      <= it.kz;
        query_time <= it.qtime;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_item(it, has, pred);
        if (has)
            pending_samples.push_back(typed ? want : pred);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // stop offering items, let every pending result drain, then hold off
    task automatic wait_quiet(int extra);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (extra)
            @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KEY_COUNT: cnt_cfg  = data[6:0];
            REG_DURATION:  clip_cfg = data;
            REG_STEP:      step_cfg = data;
            default: ;
        endcase
    endtask

    task automatic run_phase(int p);
        logic [31:0] stamps [MAX_KEYS];
        logic [31:0] base, stamp, span_end, clip, step, inc_max, q;
        logic [6:0]  kc;
        int n_use, r;
        kv_item_t it;
        base = $urandom_range(0, 32'h3FFF_FFFF);
        case (p % 3)
            0:       inc_max = 32'd16;
            1:       inc_max = 32'd65536;
            default: inc_max = 32'h0100_0000;
        endcase
        stamp = base;
        for (int k = 0; k < MAX_KEYS; k++)
        begin
            stamps[k] = stamp;
            // some duplicated times for zero-width intervals
            stamp += ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom_range(1, inc_max));
        end
        case (p)
            0:       kc = 7'd2;
            1:       kc = 7'd64;
            2:       kc = 7'd127;
            3:       kc = 7'd1;
            4:       kc = 7'($urandom_range(3, 63));
            default: kc = 7'($urandom_range(2, 64));
        endcase
        n_use = (kc > MAX_KEYS) ? MAX_KEYS : int'(kc);
        span_end = stamps[n_use-1];
        clip = span_end + 32'($urandom_range(1, 1 + (span_end - base) / 4));
        step = clip / $urandom_range(5, 40);
        if (p == 2)
        begin
            clip = 32'd0;
            step = 32'hFFFF_FFFF;
        end
        else if (p == 3)
        begin
            clip = 32'hFFFF_FFFF;
            step = $urandom;
        end

        wait_quiet(SETTLE_CYCLES);
        apb_write(REG_KEY_COUNT, {25'd0, kc});
        apb_write(REG_DURATION, clip);
        apb_write(REG_STEP, step);

        for (int k = 0; k < MAX_KEYS; k++)
            send_item(mk_write(6'(k), stamps[k], $urandom, $urandom, $urandom), 1'b0, '0);

        for (int j = 0; j < MIX_ITEMS; j++)
        begin
            if (p == 2 && j == MIX_ITEMS / 2)
                wait_quiet(0);
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                q = $urandom_range(0, 1) ? $urandom_range(base, span_end) : $urandom;
                it = mk_write(6'($urandom), q, $urandom, $urandom, $urandom);
            end
            else if (r < 55)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    q = $urandom_range(base, span_end);
                else if (r < 60)
                    q = key_t_tbl[$urandom_range(0, n_use - 1)];
                else if (r < 70)
                    q = $urandom;
                else if (r < 75)
                    q = 32'd0;
                else if (r < 85)
                    q = span_end + 32'($urandom_range(0, 64));
                else
                    q = key_t_tbl[$urandom_range(0, n_use - 1)] + ($urandom_range(0, 1) ? 1 : -1);
                it = mk_query(q);
            end
            else if (r < 95)
                it = mk_tick();
            else
            begin
                it = mk_write(6'($urandom), $urandom, $urandom, $urandom, $urandom);
                it.qtime = $urandom;
                it.cmd = CMD_NOP;
            end
            send_item(it, 1'b0, '0);
        end
    endtask

    // receiver: random back-pressure plus one long hold-off
    always @(negedge clk)
    begin
        if (!stall_done && samples_seen >= STALL_AFTER)
        begin
            stall_left = STALL_CYCLES;
            stall_done = 1'b1;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            samples_seen++;
            if (pending_samples.size() == 0)
                report_mismatch("unexpected result, used_time", used_time, 32'd0);
            else
            begin
                head_sample = pending_samples.pop_front();
                if (out_x !== head_sample.x)
                    report_mismatch("out_x", out_x, head_sample.x);
                if (out_y !== head_sample.y)
                    report_mismatch("out_y", out_y, head_sample.y);
                if (out_z !== head_sample.z)
                    report_mismatch("out_z", out_z, head_sample.z);
                if (used_time !== head_sample.used)
                    report_mismatch("used_time", used_time, head_sample.used);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d results pending", pending_samples.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        command    = CMD_WRITE;
        key_index  = '0;
        key_time   = '0;
        key_x      = '0;
        key_y      = '0;
        key_z      = '0;
        query_time = '0;
        out_ready  = 1'b0;

        clock_q  = 32'd0;
        cnt_cfg  = 7'd1;
        clip_cfg = 32'd65536;
        step_cfg = 32'd1092;

        // single key: everything returns the first value
        plan.push_back(row_item(mk_write(6'd0, 32'h0001_0000, 32'h7FFF_FFFF,
                                         32'h8000_0000, 32'h0)));
        plan.push_back(row_typed(mk_query(32'h0),
                                 mk_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0)));
        plan.push_back(row_typed(mk_query(32'hFFFF_FFFF),
                                 mk_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF)));
        plan.push_back(row_typed(mk_tick(),
                                 mk_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'd1092)));
        begin
            kv_item_t nop_it;
            nop_it = mk_write(6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            nop_it.qtime = 32'hFFFF_FFFF;
            nop_it.cmd = CMD_NOP;
            plan.push_back(row_item(nop_it));
        end
        // slot 2 repeats slot 1's time, slot 3 goes back in time
        plan.push_back(row_item(mk_write(6'd1, 32'h0002_0000, 32'h8000_0000,
                                         32'h7FFF_FFFF, 32'hFFFF_FFFF)));
        plan.push_back(row_item(mk_write(6'd2, 32'h0002_0000, 32'h0005_0000,
                                         32'h0, 32'h1234_5678)));
        plan.push_back(row_item(mk_write(6'd3, 32'h0001_8000, 32'h1,
                                         32'hFFFF_FFFF, 32'h100)));
        plan.push_back(row_cfg(REG_KEY_COUNT, 32'd4));
        plan.push_back(row_typed(mk_query(32'h0001_0000),
                                 mk_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000)));
        plan.push_back(row_item(mk_query(32'h0001_8000)));
        plan.push_back(row_item(mk_query(32'h0001_C000)));
        plan.push_back(row_item(mk_query(32'h0001_FFFF)));
        plan.push_back(row_item(mk_query(32'h0002_0000)));
        // past every interval: last value
        plan.push_back(row_typed(mk_query(32'h0003_0000),
                                 mk_sample(32'h1, 32'hFFFF_FFFF, 32'h100, 32'h0003_0000)));
        plan.push_back(row_cfg(REG_KEY_COUNT, 32'd0));
        plan.push_back(row_typed(mk_query(32'h0003_0000),
                                 mk_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0003_0000)));
        plan.push_back(row_cfg(REG_KEY_COUNT, 32'd2));
        plan.push_back(row_typed(mk_query(32'h0002_0000),
                                 mk_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                           32'h0002_0000)));
        plan.push_back(row_item(mk_query(32'h0001_8000)));
        // duration zero: wrap at 2^32 only
        plan.push_back(row_cfg(REG_DURATION, 32'd0));
        plan.push_back(row_cfg(REG_STEP, 32'hFFFF_FFFF));
        plan.push_back(row_typed(mk_tick(),
                                 mk_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'd1091)));
        plan.push_back(row_cfg(REG_DURATION, 32'd1));
        plan.push_back(row_typed(mk_tick(),
                                 mk_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0)));
        plan.push_back(row_cfg(REG_DURATION, 32'hFFFF_FFFF));
        plan.push_back(row_cfg(REG_STEP, 32'd0));
        plan.push_back(row_item(mk_tick()));

        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_quiet(SETTLE_CYCLES);
                apb_write(plan[i].reg_idx, plan[i].reg_data);
            end
            else
                send_item(plan[i].item, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 37;
                recv_idle_pct = 46;
            end
            else if (p < 4)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 37;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_phase(p);
        end

        wait_quiet(SETTLE_CYCLES);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
